// File: sv/dlbfs_pkg.sv
// ----------------------------------------------------------------------------
// dlbfs_pkg
// Shared types and constants for the depth limited breadth first search engine.
// ----------------------------------------------------------------------------
package dlbfs_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;

  localparam int VIDX_W  = $clog2(MAX_VERTICES);      // vertex index
  localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);  // vertex count
  localparam int EIDX_W  = $clog2(MAX_EDGES);         // edge slot index
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);     // edge offset
  localparam int ROW_D   = MAX_VERTICES + 1;
  localparam int ROW_AW  = $clog2(ROW_D);
  localparam int DEPTH_W = 16;
  localparam int SLOT_W  = 12;
  localparam int ACT_W   = 2;
  localparam int VD_W    = DEPTH_W + 1;               // {mark, depth}
  localparam int FIFO_W  = VIDX_W + DEPTH_W;          // {vertex, depth}

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_ROW  = 2'd0,
    ACT_LOAD_EDGE = 2'd1,
    ACT_RUN       = 2'd2,
    ACT_READ      = 2'd3
  } dlbfs_act_t;

  typedef enum logic [1:0] {
    OSEL_LOAD,
    OSEL_READ,
    OSEL_RUN
  } dlbfs_osel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_START,
    S_POP,
    S_POPW,
    S_ROW0,
    S_ROW1,
    S_EDGE,
    S_EDGEW,
    S_MARK,
    S_FIN
  } dlbfs_state_t;

  typedef struct packed {
    logic        accept;
    logic        clr_step;
    logic        start;
    logic        pop_issue;
    logic        pop_take;
    logic        row_lo;
    logic        row_hi;
    logic        edge_issue;
    logic        edge_take;
    logic        mark;
    logic        out_load;
    dlbfs_osel_t out_sel;
  } dlbfs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic src_bad;
    logic fifo_empty;
    logic ud_zero;
    logic edge_done;
    logic v_bad;
    logic v_marked;
  } dlbfs_sts_t;

endpackage

// File: sv/dlbfs_ram.sv
// ----------------------------------------------------------------------------
// dlbfs_ram
// Simple dual port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dlbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/dlbfs_ctrl.sv
// ----------------------------------------------------------------------------
// dlbfs_ctrl
// Sequencer: accepts items, steps the search and owns the result valid flag.
// ----------------------------------------------------------------------------
module dlbfs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [dlbfs_pkg::ACT_W-1:0] in_action,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  dlbfs_pkg::dlbfs_sts_t sts,
  output dlbfs_pkg::dlbfs_cmd_t cmd
);

  dlbfs_pkg::dlbfs_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlbfs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.out_sel = dlbfs_pkg::OSEL_LOAD;
    in_stall    = 1'b1;
    case (state_r)
      dlbfs_pkg::S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          cmd.accept = 1'b1;
          case (dlbfs_pkg::dlbfs_act_t'(in_action))
            dlbfs_pkg::ACT_READ: state_nxt = dlbfs_pkg::S_READ;
            dlbfs_pkg::ACT_RUN:  state_nxt = dlbfs_pkg::S_CLEAR;
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = dlbfs_pkg::OSEL_LOAD;
            end
          endcase
        end
      end
      dlbfs_pkg::S_READ: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = dlbfs_pkg::OSEL_READ;
          state_nxt    = dlbfs_pkg::S_IDLE;
        end
      end
      dlbfs_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = dlbfs_pkg::S_START;
      end
      dlbfs_pkg::S_START: begin
        if (sts.src_bad) begin
          state_nxt = dlbfs_pkg::S_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = dlbfs_pkg::S_POP;
        end
      end
      dlbfs_pkg::S_POP: begin
        if (sts.fifo_empty) begin
          state_nxt = dlbfs_pkg::S_FIN;
        end else begin
          cmd.pop_issue = 1'b1;
          state_nxt     = dlbfs_pkg::S_POPW;
        end
      end
      dlbfs_pkg::S_POPW: begin
        cmd.pop_take = 1'b1;
        state_nxt    = sts.ud_zero ? dlbfs_pkg::S_POP : dlbfs_pkg::S_ROW0;
      end
      dlbfs_pkg::S_ROW0: begin
        cmd.row_lo = 1'b1;
        state_nxt  = dlbfs_pkg::S_ROW1;
      end
      dlbfs_pkg::S_ROW1: begin
        cmd.row_hi = 1'b1;
        state_nxt  = dlbfs_pkg::S_EDGE;
      end
      dlbfs_pkg::S_EDGE: begin
        if (sts.edge_done) begin
          state_nxt = dlbfs_pkg::S_POP;
        end else begin
          cmd.edge_issue = 1'b1;
          state_nxt      = dlbfs_pkg::S_EDGEW;
        end
      end
      dlbfs_pkg::S_EDGEW: begin
        cmd.edge_take = 1'b1;
        state_nxt     = sts.v_bad ? dlbfs_pkg::S_EDGE : dlbfs_pkg::S_MARK;
      end
      dlbfs_pkg::S_MARK: begin
        cmd.mark  = !sts.v_marked;
        state_nxt = dlbfs_pkg::S_EDGE;
      end
      dlbfs_pkg::S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = dlbfs_pkg::OSEL_RUN;
          state_nxt    = dlbfs_pkg::S_IDLE;
        end
      end
      default: state_nxt = dlbfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/dlbfs_dp.sv
// ----------------------------------------------------------------------------
// dlbfs_dp
// Datapath: graph stores, visit store, frontier queue, counters and results.
// ----------------------------------------------------------------------------
module dlbfs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dlbfs_pkg::VCNT_W-1:0]       cfg_wdata,
  input  logic [dlbfs_pkg::ACT_W-1:0]        in_action,
  input  logic [dlbfs_pkg::SLOT_W-1:0]       in_slot,
  input  logic [dlbfs_pkg::ECNT_W-1:0]       in_load_value,
  input  logic [dlbfs_pkg::VIDX_W-1:0]       in_source_vertex,
  input  logic [dlbfs_pkg::DEPTH_W-1:0]      in_depth_budget,
  input  dlbfs_pkg::dlbfs_cmd_t              cmd,
  output dlbfs_pkg::dlbfs_sts_t              sts,
  output logic                               out_reached,
  output logic [dlbfs_pkg::DEPTH_W-1:0]      out_remaining_depth,
  output logic [dlbfs_pkg::VCNT_W-1:0]       out_reached_total,
  output logic                               out_status
);

  localparam int VW = dlbfs_pkg::VIDX_W;
  localparam int DW = dlbfs_pkg::DEPTH_W;
  localparam int CW = dlbfs_pkg::VCNT_W;
  localparam int EW = dlbfs_pkg::ECNT_W;
  localparam int SLOT_W_P1 = dlbfs_pkg::SLOT_W + 1;

  logic [CW-1:0] vcount_r;
  logic          ran_r;
  logic          read_bad_r;
  logic [VW-1:0] src_r, cnt_r, u_r, v_r;
  logic [DW-1:0] budget_r, ud_r;
  logic [CW-1:0] head_r, tail_r, total_r;
  logic [EW-1:0] e_r, hi_r;

  logic          out_reached_r, out_status_r;
  logic [DW-1:0] out_rem_r;
  logic [CW-1:0] out_total_r;

  // Store ports.
  logic                            row_we, row_re;
  logic [dlbfs_pkg::ROW_AW-1:0]    row_raddr;
  logic [EW-1:0]                   row_rd;
  logic                            edge_we, edge_re;
  logic [VW-1:0]                   edge_rd;
  logic                            vd_we, vd_re;
  logic [VW-1:0]                   vd_waddr, vd_raddr;
  logic [dlbfs_pkg::VD_W-1:0]      vd_wdata, vd_rd;
  logic                            fifo_we;
  logic [VW-1:0]                   fifo_waddr;
  logic [dlbfs_pkg::FIFO_W-1:0]    fifo_wdata, fifo_rd;

  logic          is_row, is_edge, is_read, is_run;
  logic          row_bad, edge_bad, load_bad, slot_bad;
  logic [EW-1:0] hi_cut;
  logic [DW-1:0] ud_dec;

  assign is_row  = in_action == dlbfs_pkg::ACT_LOAD_ROW;
  assign is_edge = in_action == dlbfs_pkg::ACT_LOAD_EDGE;
  assign is_read = in_action == dlbfs_pkg::ACT_READ;
  assign is_run  = in_action == dlbfs_pkg::ACT_RUN;

  assign row_bad  = ({1'b0, in_slot} > (SLOT_W_P1'(dlbfs_pkg::MAX_VERTICES)))
                 || (in_load_value > EW'(dlbfs_pkg::MAX_EDGES));
  assign edge_bad = ({1'b0, in_slot} >= (SLOT_W_P1'(dlbfs_pkg::MAX_EDGES)))
                 || (in_load_value >= EW'(dlbfs_pkg::MAX_VERTICES));
  assign load_bad = is_row ? row_bad : edge_bad;
  assign slot_bad = in_slot >= dlbfs_pkg::SLOT_W'(vcount_r);

  assign ud_dec = ud_r - DW'(1);
  assign hi_cut = (row_rd > EW'(dlbfs_pkg::MAX_EDGES)) ? EW'(dlbfs_pkg::MAX_EDGES) : row_rd;

  // Status back to the sequencer.
  assign sts.clr_last   = cnt_r == VW'(dlbfs_pkg::MAX_VERTICES - 1);
  assign sts.src_bad    = CW'(src_r) >= vcount_r;
  assign sts.fifo_empty = head_r == tail_r;
  assign sts.ud_zero    = fifo_rd[DW-1:0] == '0;
  assign sts.edge_done  = e_r >= hi_r;
  assign sts.v_bad      = CW'(edge_rd) >= vcount_r;
  assign sts.v_marked   = vd_rd[DW];

  // Row offset store.
  assign row_we    = cmd.accept && is_row && !row_bad;
  assign row_re    = cmd.pop_take || cmd.row_lo;
  assign row_raddr = cmd.pop_take ? dlbfs_pkg::ROW_AW'(fifo_rd[dlbfs_pkg::FIFO_W-1:DW])
                                  : dlbfs_pkg::ROW_AW'(u_r) + dlbfs_pkg::ROW_AW'(1);

  dlbfs_ram #(.WIDTH(EW), .DEPTH(dlbfs_pkg::ROW_D)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (in_slot[dlbfs_pkg::ROW_AW-1:0]),
    .wdata (in_load_value),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rd)
  );

  // Edge target store.
  assign edge_we = cmd.accept && is_edge && !edge_bad;
  assign edge_re = cmd.edge_issue;

  dlbfs_ram #(.WIDTH(VW), .DEPTH(dlbfs_pkg::MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (in_slot[dlbfs_pkg::EIDX_W-1:0]),
    .wdata (in_load_value[VW-1:0]),
    .re    (edge_re),
    .raddr (e_r[dlbfs_pkg::EIDX_W-1:0]),
    .rdata (edge_rd)
  );

  // Visit mark and remaining depth store.
  always_comb begin
    vd_we    = cmd.clr_step || cmd.start || cmd.mark;
    vd_waddr = cnt_r;
    vd_wdata = '0;
    if (cmd.start) begin
      vd_waddr = src_r;
      vd_wdata = {1'b1, budget_r};
    end else if (cmd.mark) begin
      vd_waddr = v_r;
      vd_wdata = {1'b1, ud_dec};
    end
  end

  assign vd_re    = (cmd.accept && is_read) || cmd.edge_take;
  assign vd_raddr = cmd.accept ? in_slot[VW-1:0] : edge_rd;

  dlbfs_ram #(.WIDTH(dlbfs_pkg::VD_W), .DEPTH(dlbfs_pkg::MAX_VERTICES)) u_vd_ram (
    .clk   (clk),
    .we    (vd_we),
    .waddr (vd_waddr),
    .wdata (vd_wdata),
    .re    (vd_re),
    .raddr (vd_raddr),
    .rdata (vd_rd)
  );

  // Frontier queue. Each vertex enters at most once, so it never overflows.
  assign fifo_we    = cmd.start || cmd.mark;
  assign fifo_waddr = cmd.start ? '0 : tail_r[VW-1:0];
  assign fifo_wdata = cmd.start ? {src_r, budget_r} : {v_r, ud_dec};

  dlbfs_ram #(.WIDTH(dlbfs_pkg::FIFO_W), .DEPTH(dlbfs_pkg::MAX_VERTICES)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .re    (cmd.pop_issue),
    .raddr (head_r[VW-1:0]),
    .rdata (fifo_rd)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CW'(dlbfs_pkg::MAX_VERTICES);
      ran_r    <= 1'b0;
      cnt_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) vcount_r <= CW'(1);
        else if (cfg_wdata > CW'(dlbfs_pkg::MAX_VERTICES))
          vcount_r <= CW'(dlbfs_pkg::MAX_VERTICES);
        else vcount_r <= cfg_wdata;
      end
      if (cmd.accept && is_run) begin
        ran_r   <= 1'b1;
        cnt_r   <= '0;
        head_r  <= '0;
        tail_r  <= '0;
        total_r <= '0;
      end
      if (cmd.clr_step) cnt_r <= cnt_r + VW'(1);
      if (cmd.start) begin
        tail_r  <= CW'(1);
        total_r <= CW'(1);
      end
      if (cmd.mark) begin
        tail_r  <= tail_r + CW'(1);
        total_r <= total_r + CW'(1);
      end
      if (cmd.pop_issue) head_r <= head_r + CW'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src_r      <= in_source_vertex;
      budget_r   <= in_depth_budget;
      read_bad_r <= slot_bad;
    end
    if (cmd.pop_take) begin
      u_r  <= fifo_rd[dlbfs_pkg::FIFO_W-1:DW];
      ud_r <= fifo_rd[DW-1:0];
    end
    if (cmd.row_lo)     e_r  <= row_rd;
    if (cmd.row_hi)     hi_r <= hi_cut;
    if (cmd.edge_issue) e_r  <= e_r + EW'(1);
    if (cmd.edge_take)  v_r  <= edge_rd;
    if (cmd.out_load) begin
      out_reached_r <= 1'b0;
      out_rem_r     <= '0;
      out_total_r   <= '0;
      out_status_r  <= 1'b0;
      case (cmd.out_sel)
        dlbfs_pkg::OSEL_LOAD: out_status_r <= load_bad;
        dlbfs_pkg::OSEL_READ: begin
          out_status_r  <= read_bad_r;
          out_reached_r <= !read_bad_r && ran_r && vd_rd[DW];
          out_rem_r     <= (!read_bad_r && ran_r && vd_rd[DW]) ? vd_rd[DW-1:0] : '0;
        end
        dlbfs_pkg::OSEL_RUN: begin
          out_status_r <= sts.src_bad;
          out_total_r  <= sts.src_bad ? '0 : total_r;
        end
        default: out_status_r <= 1'b0;
      endcase
    end
  end

  assign out_reached         = out_reached_r;
  assign out_remaining_depth = out_rem_r;
  assign out_reached_total   = out_total_r;
  assign out_status          = out_status_r;

endmodule

// File: sv/depth_limited_bfs_engine.sv
// ----------------------------------------------------------------------------
// depth_limited_bfs_engine
// Depth limited breadth first search over a graph held in compressed rows.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ channel (in_valid, in_stall) and every item
// returns exactly one result item on the out_ channel (out_valid, out_stall).
// The in_action field picks a row offset load, an edge target load, a search
// run or a vertex read. Row offsets and edge targets are written into on-chip
// RAMs the cycle the item is taken, and their result is registered at the same
// edge, so loads go at one item per cycle while out_stall does not hold a
// result. A read passes through the S_READ state because the visit store has
// a registered read port. A run first sweeps the visit store, one entry per
// cycle, then pops the frontier queue and expands each popped vertex, all
// bound by the single read port of each RAM. One item is in flight at a
// time. Reset (rst_n low at a clock edge) empties the output, returns the
// sequencer to idle and sets the vertex count to 1024; the graph stores keep
// whatever they held. While out_stall holds a result, the block finishes its
// current item and then waits with in_stall high.
// ----------------------------------------------------------------------------
module depth_limited_bfs_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dlbfs_pkg::VCNT_W-1:0]       cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dlbfs_pkg::ACT_W-1:0]        in_action,
  input  logic [dlbfs_pkg::SLOT_W-1:0]       in_slot,
  input  logic [dlbfs_pkg::ECNT_W-1:0]       in_load_value,
  input  logic [dlbfs_pkg::VIDX_W-1:0]       in_source_vertex,
  input  logic [dlbfs_pkg::DEPTH_W-1:0]      in_depth_budget,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_reached,
  output logic [dlbfs_pkg::DEPTH_W-1:0]      out_remaining_depth,
  output logic [dlbfs_pkg::VCNT_W-1:0]       out_reached_total,
  output logic                               out_status
);

  dlbfs_pkg::dlbfs_cmd_t cmd;
  dlbfs_pkg::dlbfs_sts_t sts;

  // The sequencer decides what happens each cycle; the datapath holds all
  // storage and reports the conditions the sequencer branches on.
  dlbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlbfs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_action           (in_action),
    .in_slot             (in_slot),
    .in_load_value       (in_load_value),
    .in_source_vertex    (in_source_vertex),
    .in_depth_budget     (in_depth_budget),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_reached         (out_reached),
    .out_remaining_depth (out_remaining_depth),
    .out_reached_total   (out_reached_total),
    .out_status          (out_status)
  );

  // A reached vertex is never reported together with an error.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reached |-> !out_status)
    else $error("reached vertex reported with error status");

  // An unreached vertex always reads back a zero remaining depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reached |-> out_remaining_depth == '0)
    else $error("nonzero depth for unreached vertex");

  // An error result never carries a vertex total.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_reached_total == '0)
    else $error("error result carries a total");

  // Once a run is taken, the block holds off further items.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == dlbfs_pkg::ACT_RUN |=> in_stall)
    else $error("item accepted during a run");

endmodule

// File: dv/tb_depth_limited_bfs_engine.sv
// ----------------------------------------------------------------------------
// tb_depth_limited_bfs_engine
// Self-checking bench for the depth limited breadth first search engine.
// ----------------------------------------------------------------------------
// The bench fills the low rows and edge slots, then runs a directed set of
// items and three random phases, each under its own vertex count. A
// scoreboard object mirrors the graph, the visit marks and the depths. It
// predicts the result of every accepted item and compares the results in
// order. A run that would read a graph entry never written is turned into a
// read before it is offered.
// ----------------------------------------------------------------------------
module tb_depth_limited_bfs_engine;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dlbfs_pkg::dlbfs_act_t                action;
    logic [dlbfs_pkg::SLOT_W-1:0]         slot;
    logic [dlbfs_pkg::ECNT_W-1:0]         load_value;
    logic [dlbfs_pkg::VIDX_W-1:0]         source_vertex;
    logic [dlbfs_pkg::DEPTH_W-1:0]        depth_budget;
  } bfs_item_t;

  typedef struct {
    logic                                 reached;
    logic [dlbfs_pkg::DEPTH_W-1:0]        remaining_depth;
    logic [dlbfs_pkg::VCNT_W-1:0]         reached_total;
    logic                                 status;
  } bfs_result_t;

  // Mirror of the engine. It computes the result of each item when the item is
  // accepted, so the queue holds expected results in order of acceptance.
  class bfs_scoreboard;
    logic [dlbfs_pkg::ECNT_W-1:0]  row_start [dlbfs_pkg::ROW_D];
    logic [dlbfs_pkg::VIDX_W-1:0]  edge_dest [dlbfs_pkg::MAX_EDGES];
    bit                            row_set [dlbfs_pkg::ROW_D];
    bit                            edge_set [dlbfs_pkg::MAX_EDGES];
    bit                            seen [dlbfs_pkg::MAX_VERTICES];
    logic [dlbfs_pkg::DEPTH_W-1:0] hops_left [dlbfs_pkg::MAX_VERTICES];
    int                            vertex_limit = dlbfs_pkg::MAX_VERTICES;
    bfs_result_t                   awaited [$];
    int                            errors = 0;

    function void set_vertex_count(logic [dlbfs_pkg::VCNT_W-1:0] value);
      if (value == 0) vertex_limit = 1;
      else if (value > dlbfs_pkg::MAX_VERTICES) vertex_limit = dlbfs_pkg::MAX_VERTICES;
      else vertex_limit = int'(value);
    endfunction

    // Walks a run without touching the mirror and tells whether every row
    // offset and edge target it reads has been written.
    function bit run_safe(int src, logic [dlbfs_pkg::DEPTH_W-1:0] budget);
      bit                            mark [dlbfs_pkg::MAX_VERTICES];
      logic [dlbfs_pkg::DEPTH_W-1:0] left [dlbfs_pkg::MAX_VERTICES];
      int                            frontier [$];
      int                            u, lo, hi, v;
      if (src >= vertex_limit) return 1;
      mark[src] = 1;
      left[src] = budget;
      frontier.push_back(src);
      while (frontier.size() != 0) begin
        u = frontier.pop_front();
        if (left[u] == 0) continue;
        if (!row_set[u] || !row_set[u + 1]) return 0;
        lo = row_start[u];
        hi = row_start[u + 1];
        if (hi > dlbfs_pkg::MAX_EDGES) hi = dlbfs_pkg::MAX_EDGES;
        for (int e = lo; e < hi; e++) begin
          if (!edge_set[e]) return 0;
          v = edge_dest[e];
          if (v >= vertex_limit || mark[v]) continue;
          mark[v] = 1;
          left[v] = left[u] - 1'b1;
          frontier.push_back(v);
        end
      end
      return 1;
    endfunction

    function int walk(int src, logic [dlbfs_pkg::DEPTH_W-1:0] budget);
      int frontier [$];
      int u, lo, hi, v, total;
      foreach (seen[i]) seen[i] = 0;
      if (src >= vertex_limit) return -1;
      seen[src] = 1;
      hops_left[src] = budget;
      frontier.push_back(src);
      total = 1;
      while (frontier.size() != 0) begin
        u = frontier.pop_front();
        if (hops_left[u] == 0) continue;
        lo = row_start[u];
        hi = row_start[u + 1];
        if (hi > dlbfs_pkg::MAX_EDGES) hi = dlbfs_pkg::MAX_EDGES;
        for (int e = lo; e < hi; e++) begin
          v = edge_dest[e];
          if (v >= vertex_limit || seen[v]) continue;
          seen[v] = 1;
          hops_left[v] = hops_left[u] - 1'b1;
          frontier.push_back(v);
          total++;
        end
      end
      return total;
    endfunction

    function void note_item(bfs_item_t it);
      bfs_result_t r;
      int t;
      r = '{0, 0, 0, 0};
      case (it.action)
        dlbfs_pkg::ACT_LOAD_ROW: begin
          if (it.slot > dlbfs_pkg::MAX_VERTICES || it.load_value > dlbfs_pkg::MAX_EDGES) begin
            r.status = 1;
          end else begin
            row_start[it.slot] = it.load_value;
            row_set[it.slot]   = 1;
          end
        end
        dlbfs_pkg::ACT_LOAD_EDGE: begin
          if (it.slot >= dlbfs_pkg::MAX_EDGES || it.load_value >= dlbfs_pkg::MAX_VERTICES) begin
            r.status = 1;
          end else begin
            edge_dest[it.slot] = it.load_value[dlbfs_pkg::VIDX_W-1:0];
            edge_set[it.slot]  = 1;
          end
        end
        dlbfs_pkg::ACT_RUN: begin
          t = walk(it.source_vertex, it.depth_budget);
          if (t < 0) r.status = 1;
          else r.reached_total = dlbfs_pkg::VCNT_W'(t);
        end
        default: begin
          if (it.slot >= vertex_limit) begin
            r.status = 1;
          end else if (seen[it.slot]) begin
            r.reached = 1;
            r.remaining_depth = hops_left[it.slot];
          end
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(bfs_result_t got);
      bfs_result_t exp_r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result reached=%0d remaining=%0d total=%0d status=%0d",
                 $time, got.reached, got.remaining_depth, got.reached_total, got.status);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.reached !== exp_r.reached) begin
        $display("%0t: reached expected %0d actual %0d", $time, exp_r.reached, got.reached);
        errors++;
      end
      if (got.remaining_depth !== exp_r.remaining_depth) begin
        $display("%0t: remaining_depth expected %0d actual %0d", $time,
                 exp_r.remaining_depth, got.remaining_depth);
        errors++;
      end
      if (got.reached_total !== exp_r.reached_total) begin
        $display("%0t: reached_total expected %0d actual %0d", $time,
                 exp_r.reached_total, got.reached_total);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 200000;

  logic                            clk = 0;
  logic                            rst_n = 0;
  logic                            cfg_we = 0;
  logic [dlbfs_pkg::VCNT_W-1:0]    cfg_wdata = '0;
  logic                            in_valid = 0;
  logic                            in_stall;
  logic [dlbfs_pkg::ACT_W-1:0]     in_action = '0;
  logic [dlbfs_pkg::SLOT_W-1:0]    in_slot = '0;
  logic [dlbfs_pkg::ECNT_W-1:0]    in_load_value = '0;
  logic [dlbfs_pkg::VIDX_W-1:0]    in_source_vertex = '0;
  logic [dlbfs_pkg::DEPTH_W-1:0]   in_depth_budget = '0;
  logic                            out_valid;
  logic                            out_stall = 0;
  logic                            out_reached;
  logic [dlbfs_pkg::DEPTH_W-1:0]   out_remaining_depth;
  logic [dlbfs_pkg::VCNT_W-1:0]    out_reached_total;
  logic                            out_status;

  // Idle rates in percent for the sender and the receiver, and a flag that
  // makes the receiver hold off completely for a long stretch.
  int send_idle_pct = 35;
  int recv_idle_pct = 62;
  logic recv_hold = 0;
  int quiet_cycles = 0;
  int cur_vertices = dlbfs_pkg::MAX_VERTICES;

  bfs_scoreboard board = new();

  depth_limited_bfs_engine uut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_action, .in_slot, .in_load_value,
    .in_source_vertex, .in_depth_budget,
    .out_valid, .out_stall, .out_reached, .out_remaining_depth,
    .out_reached_total, .out_status
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Result monitor. Values read at the edge are the ones settled before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result('{out_reached, out_remaining_depth, out_reached_total, out_status});
  end

  // The watchdog counts cycles in which neither channel moves an item. A full
  // run over the largest graph stays far below the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and returns at the edge where the engine takes it. The
  // valid is left high, so a following item continues without a gap.
  task automatic send_item(bfs_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1;
    in_action        <= it.action;
    in_slot          <= it.slot;
    in_load_value    <= it.load_value;
    in_source_vertex <= it.source_vertex;
    in_depth_budget  <= it.depth_budget;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
  endtask

  task automatic send_fields(dlbfs_pkg::dlbfs_act_t act, int slot, int value, int src,
                             int budget);
    bfs_item_t it;
    it.action        = act;
    it.slot          = dlbfs_pkg::SLOT_W'(slot);
    it.load_value    = dlbfs_pkg::ECNT_W'(value);
    it.source_vertex = dlbfs_pkg::VIDX_W'(src);
    it.depth_budget  = dlbfs_pkg::DEPTH_W'(budget);
    send_item(it);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Only called while the engine is idle.
  task automatic write_vertex_count(logic [dlbfs_pkg::VCNT_W-1:0] value);
    cfg_we    <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 0;
    board.set_vertex_count(value);
    cur_vertices = board.vertex_limit;
  endtask

  // Random item biased toward small, well formed graphs in the low vertices
  // so that searches go several levels deep. About one item in ten is raw
  // noise.
  function automatic bfs_item_t random_item();
    bfs_item_t it;
    int pick;
    int span;
    pick = $urandom_range(99);
    span = (cur_vertices > 48) ? 48 : cur_vertices - 1;
    it.slot          = dlbfs_pkg::SLOT_W'($urandom);
    it.load_value    = dlbfs_pkg::ECNT_W'($urandom);
    it.source_vertex = dlbfs_pkg::VIDX_W'($urandom);
    it.depth_budget  = dlbfs_pkg::DEPTH_W'($urandom);
    if (pick < 30) it.action = dlbfs_pkg::ACT_LOAD_ROW;
    else if (pick < 60) it.action = dlbfs_pkg::ACT_LOAD_EDGE;
    else if (pick < 72) it.action = dlbfs_pkg::ACT_RUN;
    else it.action = dlbfs_pkg::ACT_READ;
    if ($urandom_range(9) != 0) begin
      case (it.action)
        dlbfs_pkg::ACT_LOAD_ROW: begin
          it.slot       = dlbfs_pkg::SLOT_W'($urandom_range(0, span + 1));
          it.load_value = dlbfs_pkg::ECNT_W'($urandom_range(0, 64));
        end
        dlbfs_pkg::ACT_LOAD_EDGE: begin
          it.slot       = dlbfs_pkg::SLOT_W'($urandom_range(0, 63));
          it.load_value = dlbfs_pkg::ECNT_W'($urandom_range(0, span));
        end
        dlbfs_pkg::ACT_RUN: begin
          it.source_vertex = dlbfs_pkg::VIDX_W'($urandom_range(0, span));
          if ($urandom_range(3) != 0)
            it.depth_budget = dlbfs_pkg::DEPTH_W'($urandom_range(0, 6));
        end
        default: it.slot = dlbfs_pkg::SLOT_W'($urandom_range(0, cur_vertices - 1));
      endcase
    end
    if (it.action == dlbfs_pkg::ACT_RUN && !board.run_safe(it.source_vertex, it.depth_budget))
      it.action = dlbfs_pkg::ACT_READ;
    return it;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Give the low row offsets and edge slots a defined value before any run.
    for (int i = 0; i < 50; i++) send_fields(dlbfs_pkg::ACT_LOAD_ROW, i, 0, 0, 0);
    for (int i = 0; i < 64; i++) send_fields(dlbfs_pkg::ACT_LOAD_EDGE, i, 0, 0, 0);
    drain_results();

    // Directed part on an eight vertex graph: a chain 0-1-2-3 with a branch,
    // one target beyond the vertex count, and a decreasing row range.
    write_vertex_count(dlbfs_pkg::VCNT_W'(8));
    send_fields(dlbfs_pkg::ACT_READ, 2, 0, 0, 0);               // unreached before any run
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 0, 1, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 1, 5, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 2, 2, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 3, 12, 0, 0);         // target past the count
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 4, 3, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 4095, 1023, 0, 0);    // top edge slot
    send_fields(dlbfs_pkg::ACT_LOAD_EDGE, 7, 1024, 0, 0);       // target out of range
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 1, 2, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 2, 4, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 3, 5, 0, 0);
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 4, 3, 0, 0);           // decreasing range
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 1024, 4096, 0, 0);     // largest slot and value
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 1025, 0, 0, 0);        // slot out of range
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 4095, 8191, 0, 0);     // both out of range
    send_fields(dlbfs_pkg::ACT_LOAD_ROW, 5, 4097, 0, 0);        // value out of range
    send_fields(dlbfs_pkg::ACT_RUN, 0, 0, 0, 65535);
    send_fields(dlbfs_pkg::ACT_READ, 3, 0, 0, 0);
    send_fields(dlbfs_pkg::ACT_READ, 5, 0, 0, 0);
    send_fields(dlbfs_pkg::ACT_RUN, 0, 0, 0, 1);
    send_fields(dlbfs_pkg::ACT_READ, 1, 0, 0, 0);
    send_fields(dlbfs_pkg::ACT_READ, 2, 0, 0, 0);               // beyond the budget
    send_fields(dlbfs_pkg::ACT_RUN, 0, 0, 0, 0);                // zero budget
    send_fields(dlbfs_pkg::ACT_RUN, 0, 0, 9, 3);                // source past the count
    send_fields(dlbfs_pkg::ACT_READ, 4095, 0, 0, 0);            // vertex out of range
    drain_results();

    // Phase one at the smallest count, sender and receiver idling.
    write_vertex_count(dlbfs_pkg::VCNT_W'(0));
    repeat (150) send_item(random_item());
    drain_results();

    // Phase two at a small count with the idle rates swapped. The receiver
    // holds off for a long stretch while items keep coming, then the sender
    // pauses until all results are home.
    write_vertex_count(dlbfs_pkg::VCNT_W'($urandom_range(2, 40)));
    send_idle_pct = 62;
    recv_idle_pct = 35;
    fork
      begin
        recv_hold <= 1;
        repeat (400) @(posedge clk);
        recv_hold <= 0;
      end
      repeat (20) send_item(random_item());
    join
    drain_results();
    repeat (150) send_item(random_item());
    drain_results();

    // Phase three at the largest count, with a register value above it.
    write_vertex_count(dlbfs_pkg::VCNT_W'(2047));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (150) send_item(random_item());
    drain_results();
    write_vertex_count(dlbfs_pkg::VCNT_W'(1024));
    repeat (10) send_item(random_item());
    drain_results();

    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
